// ----- rtl/core/frc_pkg.sv -----
`timescale 1ns / 1ps

package frc_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int URGENCY_LEVELS = 4;

    localparam int REQ_W     = 2;
    localparam int LEVEL_W   = 2;
    localparam int SINK_W    = 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_FRAME  = 2'd0,
        REQ_DONE   = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_POLL   = 2'd3
    } t_req_kind;

    typedef enum logic [SINK_W-1:0] {
        SINK_READY   = 2'd0,
        SINK_BLOCKED = 2'd1,
        SINK_UNAVAIL = 2'd2
    } t_sink;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_WINDOW  = 2'd0,
        CFG_SUST_AFTER  = 2'd1,
        CFG_SUST_DELAY  = 2'd2,
        CFG_SHORT_DELAY = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_GAP_WINDOW  = 24'd50000;
    localparam logic [CFG_W-1:0] RST_SUST_AFTER  = 24'd100000;
    localparam logic [CFG_W-1:0] RST_SUST_DELAY  = 24'd16000;
    localparam logic [CFG_W-1:0] RST_SHORT_DELAY = 24'd4000;

    localparam logic [LEVEL_W-1:0] LEVEL_BURST = '0;
    // highest urgency code the block keeps; wider settings saturate at the field width
    localparam logic [LEVEL_W-1:0] LEVEL_MAX =
        (URGENCY_LEVELS - 1 > 3) ? 2'd3 : LEVEL_W'(URGENCY_LEVELS - 1);

    typedef struct packed {
        logic [CFG_W-1:0] gap_window;
        logic [CFG_W-1:0] sust_after;
        logic [CFG_W-1:0] sust_delay;
        logic [CFG_W-1:0] short_delay;
    } t_burst_cfg;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_burst_ctl;

endpackage

// ----- rtl/core/frc_burst.sv -----
`timescale 1ns / 1ps

module frc_burst
    import frc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_burst_ctl           i_ctl,
    input  t_burst_cfg           i_cfg,
    input  logic [TIME_BITS-1:0] i_now,
    output logic [TIME_BITS-1:0] o_cand_time,
    output logic                 o_cand_reached
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int SUM_W = CMP_W + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic                 r_in_burst;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_last;

    logic [TIME_BITS:0]   w_gap_diff;
    logic [TIME_BITS:0]   w_age_diff;
    logic                 w_gap_big;
    logic                 w_restart;
    logic                 w_age_sus;
    logic [SUM_W-1:0]     w_sum_short;
    logic [SUM_W-1:0]     w_sum_sust;
    logic [TIME_BITS-1:0] w_due_short;
    logic [TIME_BITS-1:0] w_due_sust;
    logic                 w_delay_zero;

    // a borrow means time ran backwards: gap and age count as zero
    assign w_gap_diff = {1'b0, i_now} - {1'b0, r_last};
    assign w_age_diff = {1'b0, i_now} - {1'b0, r_start};

    assign w_gap_big = !w_gap_diff[TIME_BITS] &&
                       (CMP_W'(w_gap_diff[TIME_BITS-1:0]) > CMP_W'(i_cfg.gap_window));
    assign w_restart = !r_in_burst || w_gap_big;

    // a restarted burst has age zero
    always_comb begin
        if (w_restart || w_age_diff[TIME_BITS]) begin
            w_age_sus = (i_cfg.sust_after == '0);
        end else begin
            w_age_sus = (CMP_W'(w_age_diff[TIME_BITS-1:0]) >= CMP_W'(i_cfg.sust_after));
        end
    end

    assign w_sum_short = SUM_W'(i_now) + SUM_W'(i_cfg.short_delay);
    assign w_sum_sust  = SUM_W'(i_now) + SUM_W'(i_cfg.sust_delay);

    // saturate at the top of the time range
    assign w_due_short = (|w_sum_short[SUM_W-1:TIME_BITS]) ? TIME_MAX
                                                           : w_sum_short[TIME_BITS-1:0];
    assign w_due_sust  = (|w_sum_sust[SUM_W-1:TIME_BITS]) ? TIME_MAX
                                                          : w_sum_sust[TIME_BITS-1:0];

    assign o_cand_time  = w_age_sus ? w_due_sust : w_due_short;
    assign w_delay_zero = w_age_sus ? (i_cfg.sust_delay == '0) : (i_cfg.short_delay == '0);
    // now has reached now plus delay only for a zero delay or for now already at the top of the time range
    assign o_cand_reached = w_delay_zero || (&i_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_burst <= 1'b0;
            r_start    <= '0;
            r_last     <= '0;
        end else if (i_ctl.clear) begin
            r_in_burst <= 1'b0;
            r_start    <= '0;
            r_last     <= '0;
        end else if (i_ctl.advance) begin
            r_in_burst <= 1'b1;
            r_last     <= i_now;
            if (w_restart) begin
                r_start <= i_now;
            end
        end
    end

endmodule

// ----- rtl/core/frame_request_coalescer_unit.sv -----
// Frame request coalescer: merges requests into one pending frame with the earliest
// deadline, the highest urgency and a sticky full-repaint flag, and reports the frame
// state for every transaction. It accepts one transaction per clock while the result
// is not stalled and returns one result per transaction. The input register takes the
// transaction and the result register loads from it when the result side is free. A
// stalled result holds the input register, and a full input register then stalls the
// input. The pending-frame and burst-tracking state is updated in the single pass from
// the input register to the result register, so back-to-back transactions see each
// other's effect. Configuration registers must be written through the plain write port
// only while no transaction is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module frame_request_coalescer_unit
    import frc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [LEVEL_W-1:0]   i_level,
    input  logic                 i_want_full,
    input  logic [TIME_BITS-1:0] i_now_time,
    input  logic [SINK_W-1:0]    i_sink_state,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_pending,
    output logic                 o_full_needed,
    output logic [LEVEL_W-1:0]   o_cur_level,
    output logic                 o_deadline_valid,
    output logic [TIME_BITS-1:0] o_due_time,
    output logic                 o_is_due
);

    t_burst_cfg           r_cfg;

    // input register
    logic                 r_in_valid;
    t_req_kind            r_in_kind;
    logic [LEVEL_W-1:0]   r_in_level;
    logic                 r_in_want;
    logic [TIME_BITS-1:0] r_in_now;
    logic [SINK_W-1:0]    r_in_sink;

    // pending frame
    logic                 r_pending;
    logic                 r_full;
    logic [LEVEL_W-1:0]   r_level;
    logic [TIME_BITS-1:0] r_deadline;
    logic                 n_pending;
    logic                 n_full;
    logic [LEVEL_W-1:0]   n_level;
    logic [TIME_BITS-1:0] n_deadline;

    // result register
    logic                 r_out_valid;
    logic                 r_is_pending;
    logic                 r_full_needed;
    logic [LEVEL_W-1:0]   r_cur_level;
    logic                 r_deadline_valid;
    logic [TIME_BITS-1:0] r_due_time;
    logic                 r_is_due;
    logic                 n_deadline_valid;
    logic                 n_is_due;

    logic                 w_out_load;
    logic                 w_fire;
    logic                 w_in_accept;
    logic [LEVEL_W-1:0]   w_level;
    logic                 w_sink_ok;
    logic                 w_req;
    logic                 w_is_burst;
    logic [TIME_BITS-1:0] w_burst_cand;
    logic                 w_burst_reached;
    logic [TIME_BITS-1:0] w_cand;
    logic                 w_cand_reached;
    logic                 w_take_cand;
    logic                 w_now_ge_old;
    logic                 w_due_ge;
    t_burst_ctl           w_burst_ctl;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_window  <= RST_GAP_WINDOW;
            r_cfg.sust_after  <= RST_SUST_AFTER;
            r_cfg.sust_delay  <= RST_SUST_DELAY;
            r_cfg.short_delay <= RST_SHORT_DELAY;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAP_WINDOW:  r_cfg.gap_window  <= i_cfg_data;
                CFG_SUST_AFTER:  r_cfg.sust_after  <= i_cfg_data;
                CFG_SUST_DELAY:  r_cfg.sust_delay  <= i_cfg_data;
                CFG_SHORT_DELAY: r_cfg.short_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ handshake
    assign w_out_load  = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_load;
    assign o_in_stall  = r_in_valid && !w_out_load;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_kind  <= t_req_kind'(i_req_type);
            r_in_level <= i_level;
            r_in_want  <= i_want_full;
            r_in_now   <= i_now_time;
            r_in_sink  <= i_sink_state;
        end
    end

    // ---------------------------------------------------------- burst track
    assign w_level    = (int'(r_in_level) > URGENCY_LEVELS - 1) ? LEVEL_MAX : r_in_level;
    assign w_sink_ok  = (r_in_sink == SINK_READY) || (r_in_sink == SINK_BLOCKED);
    assign w_req      = (r_in_kind == REQ_FRAME) && w_sink_ok;
    assign w_is_burst = (w_level == LEVEL_BURST);

    assign w_burst_ctl.advance = w_fire && w_req && w_is_burst;
    assign w_burst_ctl.clear   = w_fire && (r_in_kind == REQ_CANCEL);

    frc_burst #(
        .TIME_BITS (TIME_BITS)
    ) u_burst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_burst_ctl),
        .i_cfg          (r_cfg),
        .i_now          (r_in_now),
        .o_cand_time    (w_burst_cand),
        .o_cand_reached (w_burst_reached)
    );

    // ---------------------------------------------------------- frame merge
    assign w_cand         = w_is_burst ? w_burst_cand : r_in_now;
    assign w_cand_reached = w_is_burst ? w_burst_reached : 1'b1;
    assign w_take_cand    = !r_pending || (w_cand < r_deadline);
    assign w_now_ge_old   = (r_in_now >= r_deadline);

    always_comb begin
        n_pending  = r_pending;
        n_full     = r_full;
        n_level    = r_level;
        n_deadline = r_deadline;
        w_due_ge   = w_now_ge_old;
        unique case (r_in_kind) inside
            REQ_FRAME: begin
                if (w_req) begin
                    n_pending = 1'b1;
                    if (w_take_cand) begin
                        n_deadline = w_cand;
                        w_due_ge   = w_cand_reached;
                    end
                    if (!r_pending || (w_level > r_level)) begin
                        n_level = w_level;
                    end
                    n_full = r_full || r_in_want || (r_in_sink == SINK_BLOCKED);
                end
            end
            REQ_DONE, REQ_CANCEL: begin
                n_pending  = 1'b0;
                n_full     = 1'b0;
                n_level    = LEVEL_BURST;
                n_deadline = '0;
            end
            REQ_POLL: ;
            default: ;
        endcase
    end

    assign n_deadline_valid = n_pending && (r_in_sink == SINK_READY);
    assign n_is_due         = n_deadline_valid && w_due_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_full     <= 1'b0;
            r_level    <= LEVEL_BURST;
            r_deadline <= '0;
        end else if (w_fire) begin
            r_pending  <= n_pending;
            r_full     <= n_full;
            r_level    <= n_level;
            r_deadline <= n_deadline;
        end
    end

    // ------------------------------------------------------------ result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_is_pending     <= n_pending;
            r_full_needed    <= n_full;
            r_cur_level      <= n_level;
            r_deadline_valid <= n_deadline_valid;
            r_due_time       <= n_deadline;
            r_is_due         <= n_is_due;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_pending     = r_is_pending;
    assign o_full_needed    = r_full_needed;
    assign o_cur_level      = r_cur_level;
    assign o_deadline_valid = r_deadline_valid;
    assign o_due_time       = r_due_time;
    assign o_is_due         = r_is_due;

`ifndef SYNTH
    a_idle_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (!r_full && (r_level == LEVEL_BURST) && (r_deadline == '0)))
        else $error("idle frame state not cleared");

    a_due_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_due) |-> (r_deadline_valid && r_is_pending))
        else $error("due reported without a valid deadline");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_is_pending == r_pending) && (r_due_time == r_deadline))
        else $error("result register disagrees with frame state");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room downstream");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import frc_pkg::*;

    localparam int TB_TIME = TIME_BITS_DEF;
    localparam logic [TB_TIME-1:0] TIME_TOP = '1;
    localparam logic [SINK_W-1:0] SINK_UNDEF = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 75;
    localparam int PHASES = 6;

    typedef struct packed {
        logic               pending;
        logic               full;
        logic [LEVEL_W-1:0] level;
        logic               dl_valid;
        logic [TB_TIME-1:0] due_time;
        logic               due;
    } t_frame_status;

    // Tracks the coalesced frame and burst timing, queues the status each
    // accepted transaction should produce, and checks results in order.
    class frame_status_board;
        logic [CFG_W-1:0]   gap_window, sust_after, sust_delay, short_delay;
        logic               pending, full, in_burst;
        logic [LEVEL_W-1:0] level;
        logic [TB_TIME-1:0] deadline, burst_start, last_burst;
        t_frame_status      expected_status[$];
        int                 errors;

        function void clear();
            gap_window  = RST_GAP_WINDOW;
            sust_after  = RST_SUST_AFTER;
            sust_delay  = RST_SUST_DELAY;
            short_delay = RST_SHORT_DELAY;
            pending     = 1'b0;
            full        = 1'b0;
            level       = LEVEL_BURST;
            deadline    = '0;
            in_burst    = 1'b0;
            burst_start = '0;
            last_burst  = '0;
            expected_status.delete();
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_GAP_WINDOW:  gap_window  = val;
                CFG_SUST_AFTER:  sust_after  = val;
                CFG_SUST_DELAY:  sust_delay  = val;
                CFG_SHORT_DELAY: short_delay = val;
                default: ;
            endcase
        endfunction

        // Advance burst tracking and return the saturated burst deadline.
        function logic [TB_TIME-1:0] next_burst_due(logic [TB_TIME-1:0] now);
            logic [TB_TIME-1:0] gap, age;
            logic [TB_TIME:0]   sum;
            gap = (now >= last_burst) ? now - last_burst : '0;
            if (!in_burst || gap > TB_TIME'(gap_window)) begin
                burst_start = now;
                in_burst    = 1'b1;
            end
            last_burst = now;
            age = (now >= burst_start) ? now - burst_start : '0;
            sum = {1'b0, now} + ((age >= TB_TIME'(sust_after)) ? TB_TIME'(sust_delay)
                                                                : TB_TIME'(short_delay));
            return sum[TB_TIME] ? TIME_TOP : sum[TB_TIME-1:0];
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [LEVEL_W-1:0] lvl,
                                   logic want_full, logic [TB_TIME-1:0] now,
                                   logic [SINK_W-1:0] sink);
            logic [LEVEL_W-1:0] l;
            logic [TB_TIME-1:0] cand;
            t_frame_status      st;
            if (kind == REQ_FRAME && (sink == SINK_READY || sink == SINK_BLOCKED)) begin
                l = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
                cand = (l == LEVEL_BURST) ? next_burst_due(now) : now;
                if (!pending || cand < deadline) deadline = cand;
                if (!pending || l > level) level = l;
                pending = 1'b1;
                full = full | want_full | (sink == SINK_BLOCKED);
            end else if (kind == REQ_DONE || kind == REQ_CANCEL) begin
                pending  = 1'b0;
                full     = 1'b0;
                level    = LEVEL_BURST;
                deadline = '0;
                if (kind == REQ_CANCEL) begin
                    in_burst    = 1'b0;
                    burst_start = '0;
                    last_burst  = '0;
                end
            end
            st.pending  = pending;
            st.full     = full;
            st.level    = level;
            st.dl_valid = pending && (sink == SINK_READY);
            st.due_time = deadline;
            st.due      = st.dl_valid && (now >= deadline);
            expected_status.push_back(st);
        endfunction

        function void check_status(t_frame_status got);
            t_frame_status exp_st;
            if (expected_status.size() == 0) begin
                $error("unexpected result transaction: nothing outstanding");
                errors++;
                return;
            end
            exp_st = expected_status.pop_front();
            if (got.pending !== exp_st.pending) begin
                $error("is_pending: expected %0h, got %0h", exp_st.pending, got.pending);
                errors++;
            end
            if (got.full !== exp_st.full) begin
                $error("full_needed: expected %0h, got %0h", exp_st.full, got.full);
                errors++;
            end
            if (got.level !== exp_st.level) begin
                $error("cur_level: expected %0h, got %0h", exp_st.level, got.level);
                errors++;
            end
            if (got.dl_valid !== exp_st.dl_valid) begin
                $error("deadline_valid: expected %0h, got %0h", exp_st.dl_valid, got.dl_valid);
                errors++;
            end
            if (got.due_time !== exp_st.due_time) begin
                $error("due_time: expected %0h, got %0h", exp_st.due_time, got.due_time);
                errors++;
            end
            if (got.due !== exp_st.due) begin
                $error("is_due: expected %0h, got %0h", exp_st.due, got.due);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [LEVEL_W-1:0]   i_level;
    logic                 i_want_full;
    logic [TB_TIME-1:0]   i_now_time;
    logic [SINK_W-1:0]    i_sink_state;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_is_pending;
    logic                 o_full_needed;
    logic [LEVEL_W-1:0]   o_cur_level;
    logic                 o_deadline_valid;
    logic [TB_TIME-1:0]   o_due_time;
    logic                 o_is_due;

    frame_status_board board;
    logic              quiet;
    logic              hold_go;
    logic              rx_hold;
    int                tx_idle_pct;
    int                cycles;

    frame_request_coalescer_unit #(
        .TIME_BITS(TB_TIME)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_level          (i_level),
        .i_want_full      (i_want_full),
        .i_now_time       (i_now_time),
        .i_sink_state     (i_sink_state),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_pending     (o_is_pending),
        .o_full_needed    (o_full_needed),
        .o_cur_level      (o_cur_level),
        .o_deadline_valid (o_deadline_valid),
        .o_due_time       (o_due_time),
        .o_is_due         (o_is_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Result side: check at the rising edge, update stall at the falling edge.
    initial begin
        int            stall_left;
        int            epoch;
        logic          rx_busy;
        t_frame_status got;
        stall_left  = 0;
        epoch       = 0;
        rx_busy     = 1'b1;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                got.pending  = o_is_pending;
                got.full     = o_full_needed;
                got.level    = o_cur_level;
                got.dl_valid = o_deadline_valid;
                got.due_time = o_due_time;
                got.due      = o_is_due;
                board.check_status(got);
            end
            @(negedge i_clk);
            epoch++;
            if (epoch % 64 == 0) rx_busy = ($urandom_range(0, 2) != 0);
            if (stall_left > 0) begin
                stall_left--;
            end else if (rx_busy && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_out_stall <= rx_hold || (stall_left > 0);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [LEVEL_W-1:0] lvl,
                             input logic want_full, input logic [TB_TIME-1:0] now,
                             input logic [SINK_W-1:0] sink);
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_level      <= lvl;
        i_want_full  <= want_full;
        i_now_time   <= now;
        i_sink_state <= sink;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(kind, lvl, want_full, now, sink);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every outstanding transaction has reported.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.expected_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] after,
                                input logic [CFG_W-1:0] sust, input logic [CFG_W-1:0] short_d);
        t_cfg_idx         regs[4];
        logic [CFG_W-1:0] vals[4];
        regs = '{CFG_GAP_WINDOW, CFG_SUST_AFTER, CFG_SUST_DELAY, CFG_SHORT_DELAY};
        vals = '{gap, after, sust, short_d};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            board.set_reg(regs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [TB_TIME-1:0] now;
        logic [CFG_W-1:0]   g, a, sd, sh;
        logic [REQ_W-1:0]   kind;
        logic [LEVEL_W-1:0] lvl;
        logic               want_full;
        logic [SINK_W-1:0]  sink;
        int                 r;

        board = new();
        board.clear();
        quiet        = 1'b0;
        hold_go      = 1'b0;
        tx_idle_pct  = 20;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_GAP_WINDOW;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_POLL;
        i_level      = LEVEL_BURST;
        i_want_full  = 1'b0;
        i_now_time   = '0;
        i_sink_state = SINK_READY;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset register values.
        send_item(REQ_POLL,   LEVEL_BURST, 1'b0, 48'd0,    SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd1000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd6000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_MAX,   1'b1, 48'd7000, SINK_READY);
        send_item(REQ_FRAME,  2'd1,        1'b0, 48'd8000, SINK_READY);
        send_item(REQ_DONE,   LEVEL_BURST, 1'b0, 48'd8500, SINK_READY);
        send_item(REQ_FRAME,  2'd2,        1'b0, 48'd9000, SINK_BLOCKED);
        send_item(REQ_FRAME,  LEVEL_MAX,   1'b0, 48'd9500, SINK_UNAVAIL);
        send_item(REQ_FRAME,  LEVEL_MAX,   1'b1, 48'd9600, SINK_UNDEF);
        send_item(REQ_POLL,   LEVEL_BURST, 1'b0, 48'd9700, SINK_READY);
        send_item(REQ_CANCEL, LEVEL_BURST, 1'b0, 48'd9800, SINK_READY);
        // burst growing into the sustained delay, then a wide gap restarts it
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd200000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd240000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd290000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd300000, SINK_READY);
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd360000, SINK_READY);
        // time running backwards
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, 48'd350000, SINK_READY);
        send_item(REQ_DONE,   LEVEL_BURST, 1'b0, 48'd350000, SINK_READY);
        // deadline saturation at the top of the time range
        send_item(REQ_FRAME,  LEVEL_BURST, 1'b0, TIME_TOP - 48'd100, SINK_READY);
        send_item(REQ_FRAME,  2'd2,        1'b1, TIME_TOP, SINK_READY);
        send_item(REQ_POLL,   LEVEL_MAX,   1'b1, TIME_TOP, SINK_BLOCKED);
        send_item(REQ_CANCEL, LEVEL_MAX,   1'b1, TIME_TOP, SINK_UNDEF);
        send_item(REQ_FRAME,  LEVEL_MAX,   1'b0, 48'd0,    SINK_READY);
        send_item(REQ_DONE,   LEVEL_BURST, 1'b0, 48'd0,    SINK_READY);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: begin
                    g = '0; a = '0; sd = '0; sh = '0;
                    now = TB_TIME'($urandom_range(0, 1000));
                end
                2: begin
                    g = '1; a = '1; sd = '1; sh = '1;
                    now = TB_TIME'({$urandom, $urandom});
                end
                3: begin
                    g = CFG_W'($urandom); a = CFG_W'($urandom);
                    sd = CFG_W'($urandom); sh = CFG_W'($urandom);
                    now = TB_TIME'({$urandom, $urandom});
                end
                4: begin
                    g = '1; a = '0; sd = CFG_W'($urandom); sh = '1;
                    now = TIME_TOP - TB_TIME'($urandom_range(0, 1000000));
                end
                default: begin
                    g  = CFG_W'($urandom_range(0, 3000));
                    a  = CFG_W'($urandom_range(0, 8000));
                    sd = CFG_W'($urandom_range(0, 20000));
                    sh = CFG_W'($urandom_range(0, 5000));
                    now = TB_TIME'($urandom_range(0, 1000));
                end
            endcase
            write_config(g, a, sd, sh);
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            if (ph == 2) hold_go = 1'b1;
            if (ph == PHASES - 1) quiet = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                kind = (r < 62) ? REQ_FRAME : (r < 72) ? REQ_DONE :
                       (r < 78) ? REQ_CANCEL : REQ_POLL;
                lvl = $urandom_range(0, 1) ? LEVEL_BURST : LEVEL_W'($urandom_range(0, 3));
                want_full = ($urandom_range(0, 5) == 0);
                r = $urandom_range(0, 99);
                sink = (r < 70) ? SINK_READY : (r < 84) ? SINK_BLOCKED :
                       (r < 95) ? SINK_UNAVAIL : SINK_UNDEF;
                // advance time: mostly inside the burst window, some at its edge,
                // some long jumps, a few backwards steps and jumps near the top
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    now = now;
                end else if (r < 55) begin
                    now = now + TB_TIME'($urandom_range(0, board.gap_window / 2));
                end else if (r < 65) begin
                    now = now + TB_TIME'(board.gap_window) +
                          TB_TIME'($urandom_range(0, 2)) - TB_TIME'(1);
                end else if (r < 85) begin
                    now = now + TB_TIME'($urandom_range(0, board.sust_after));
                end else if (r < 90) begin
                    now = now - TB_TIME'($urandom_range(0, board.gap_window));
                end else if (r < 94) begin
                    now = TIME_TOP - TB_TIME'($urandom_range(0, 20000));
                end else begin
                    now = TB_TIME'({$urandom, $urandom});
                end
                send_item(kind, lvl, want_full, now, sink);
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- frame_request_coalescer_unit.f -----
rtl/core/frc_pkg.sv
rtl/core/frc_burst.sv
rtl/core/frame_request_coalescer_unit.sv
test/tb.sv
